// ===== rtl/irpd_pkg.sv =====
// Shared types, register map and reset values for the infrared
// pulse-distance frame encoder. No dependencies.
package irpd_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned QueueDepth = 2;

  localparam logic [TimeW-1:0] LeaderMarkReset  = 16'd9000;
  localparam logic [TimeW-1:0] LeaderSpaceReset = 16'd4500;
  localparam logic [TimeW-1:0] BitMarkReset     = 16'd562;
  localparam logic [TimeW-1:0] ZeroSpaceReset   = 16'd562;
  localparam logic [TimeW-1:0] OneSpaceReset    = 16'd1687;
  localparam logic [TimeW-1:0] TrailerMarkReset = 16'd610;
  localparam logic [TimeW-1:0] GapReset         = 16'd20000;
  localparam logic [DutyW-1:0] CarrierDutyReset = 8'd102;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEADER_MARK  = 4'd0,
    REG_LEADER_SPACE = 4'd1,
    REG_BIT_MARK     = 4'd2,
    REG_ZERO_SPACE   = 4'd3,
    REG_ONE_SPACE    = 4'd4,
    REG_TRAILER_MARK = 4'd5,
    REG_GAP          = 4'd6,
    REG_CARRIER_DUTY = 4'd7
  } reg_idx_e;

  // Segments of a frame in the order they go out.
  typedef enum logic [2:0] {
    SEG_LEAD_MARK  = 3'd0,
    SEG_LEAD_SPACE = 3'd1,
    SEG_BIT_MARK   = 3'd2,
    SEG_BIT_SPACE  = 3'd3,
    SEG_TRAIL_MARK = 3'd4,
    SEG_GAP        = 3'd5
  } seg_e;

  typedef struct packed {
    logic [TimeW-1:0] leader_mark_us;
    logic [TimeW-1:0] leader_space_us;
    logic [TimeW-1:0] bit_mark_us;
    logic [TimeW-1:0] zero_space_us;
    logic [TimeW-1:0] one_space_us;
    logic [TimeW-1:0] trailer_mark_us;
    logic [TimeW-1:0] gap_us;
    logic [DutyW-1:0] carrier_duty;
  } cfg_t;

  // A classified bit: the run of segments it produces and its data value.
  typedef struct packed {
    seg_e start_seg;
    seg_e end_seg;
    logic bit_value;
  } cmd_t;

endpackage

// ===== rtl/irpd_if.sv =====
// Valid/ready channel interfaces for frame bits in and carrier segments out.
// Depends on irpd_pkg for field widths.
interface irpd_bit_if;
  logic valid;
  logic ready;
  logic bit_value;
  logic first_bit;
  logic last_bit;

  modport source (output valid, output bit_value, output first_bit, output last_bit,
                  input ready);
  modport sink (input valid, input bit_value, input first_bit, input last_bit,
                output ready);
endinterface

interface irpd_seg_if;
  logic                      valid;
  logic                      ready;
  logic [irpd_pkg::DutyW-1:0] segment_duty;
  logic [irpd_pkg::TimeW-1:0] segment_us;
  logic                      last_segment;

  modport source (output valid, output segment_duty, output segment_us,
                  output last_segment, input ready);
  modport sink (input valid, input segment_duty, input segment_us,
                input last_segment, output ready);
endinterface

// ===== rtl/ir_pulse_distance_frame_encoder_unit.sv =====
// Top level of the infrared pulse-distance frame encoder: timing registers,
// front end, command queue and segment sequencer. Depends on irpd_pkg, irpd_if,
// irpd_front, irpd_queue and irpd_back.
//
// Each accepted frame bit becomes two carrier segments (mark, then a space set
// by the bit value), four when it is flagged first (leader mark and space ahead)
// or last (trailer mark and gap after), and six when it is both. Segments leave
// on the output channel one per cycle while the receiver is ready, from a
// registered output slot, so back-to-back bits stream with no idle cycle between
// them; that one-segment-per-cycle output register sets the rate. A queue of
// QueueDepth commands lets new bits be accepted while the sequencer is still
// working and the output is stalled. The timing registers
// are written through the configuration port (index 0 to 7, higher indexes are
// ignored) and should be changed only while no frame is in flight.
module ir_pulse_distance_frame_encoder_unit #(
  parameter int unsigned QueueDepth = irpd_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [irpd_pkg::CfgDataW-1:0] cfg_data_i,
  irpd_bit_if.sink                      bit_i,
  irpd_seg_if.source                    seg_o
);

  irpd_pkg::cfg_t cfg_q, cfg_d;
  irpd_pkg::cmd_t push_cmd, pop_cmd;
  logic push, full, pop, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        irpd_pkg::REG_LEADER_MARK:  cfg_d.leader_mark_us  = cfg_data_i;
        irpd_pkg::REG_LEADER_SPACE: cfg_d.leader_space_us = cfg_data_i;
        irpd_pkg::REG_BIT_MARK:     cfg_d.bit_mark_us     = cfg_data_i;
        irpd_pkg::REG_ZERO_SPACE:   cfg_d.zero_space_us   = cfg_data_i;
        irpd_pkg::REG_ONE_SPACE:    cfg_d.one_space_us    = cfg_data_i;
        irpd_pkg::REG_TRAILER_MARK: cfg_d.trailer_mark_us = cfg_data_i;
        irpd_pkg::REG_GAP:          cfg_d.gap_us          = cfg_data_i;
        irpd_pkg::REG_CARRIER_DUTY: cfg_d.carrier_duty    = cfg_data_i[irpd_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mark_us  <= irpd_pkg::LeaderMarkReset;
      cfg_q.leader_space_us <= irpd_pkg::LeaderSpaceReset;
      cfg_q.bit_mark_us     <= irpd_pkg::BitMarkReset;
      cfg_q.zero_space_us   <= irpd_pkg::ZeroSpaceReset;
      cfg_q.one_space_us    <= irpd_pkg::OneSpaceReset;
      cfg_q.trailer_mark_us <= irpd_pkg::TrailerMarkReset;
      cfg_q.gap_us          <= irpd_pkg::GapReset;
      cfg_q.carrier_duty    <= irpd_pkg::CarrierDutyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  irpd_front u_front (
    .bit_i  (bit_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  irpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  irpd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .seg_o   (seg_o)
  );

endmodule

// ===== rtl/irpd_front.sv =====
// Front end: accepts frame bits and classifies each into a segment run.
// Depends on irpd_pkg and irpd_if.
module irpd_front (
  irpd_bit_if.sink    bit_i,
  input  logic        full_i,
  output logic        push_o,
  output irpd_pkg::cmd_t cmd_o
);

  assign bit_i.ready = !full_i;
  assign push_o      = bit_i.valid && !full_i;

  always_comb begin
    cmd_o.bit_value = bit_i.bit_value;
    cmd_o.start_seg = bit_i.first_bit ? irpd_pkg::SEG_LEAD_MARK : irpd_pkg::SEG_BIT_MARK;
    cmd_o.end_seg   = bit_i.last_bit ? irpd_pkg::SEG_GAP : irpd_pkg::SEG_BIT_SPACE;
  end

endmodule

// ===== rtl/irpd_queue.sv =====
// Small command queue that decouples the front end from the segment sequencer.
// Depends on irpd_pkg.
module irpd_queue #(
  parameter int unsigned Depth = irpd_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  irpd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output irpd_pkg::cmd_t pop_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  irpd_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/irpd_back.sv =====
// Back end: steps through the segment run of each queued command and
// drives the registered segment output. Depends on irpd_pkg and irpd_if.
module irpd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  irpd_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  input  irpd_pkg::cmd_t cmd_i,
  output logic           pop_o,
  irpd_seg_if.source     seg_o
);

  logic           busy_q, busy_d;
  irpd_pkg::cmd_t cmd_q, cmd_d;
  irpd_pkg::seg_e seg_q, seg_d, seg_next;
  logic           out_valid_q, out_valid_d;
  logic [irpd_pkg::DutyW-1:0] duty_q, duty_d;
  logic [irpd_pkg::TimeW-1:0] us_q, us_d;
  logic           last_q, last_d;
  logic           load, emit, done;

  // The output slot takes a new segment when empty or when it is being transferred.
  assign load  = !out_valid_q || seg_o.ready;
  assign emit  = load && busy_q;
  assign done  = emit && (seg_q == cmd_q.end_seg);
  assign pop_o = !empty_i && (!busy_q || done);

  always_comb begin
    unique case (seg_q)
      irpd_pkg::SEG_LEAD_MARK:  seg_next = irpd_pkg::SEG_LEAD_SPACE;
      irpd_pkg::SEG_LEAD_SPACE: seg_next = irpd_pkg::SEG_BIT_MARK;
      irpd_pkg::SEG_BIT_MARK:   seg_next = irpd_pkg::SEG_BIT_SPACE;
      irpd_pkg::SEG_BIT_SPACE:  seg_next = irpd_pkg::SEG_TRAIL_MARK;
      irpd_pkg::SEG_TRAIL_MARK: seg_next = irpd_pkg::SEG_GAP;
      default:                  seg_next = irpd_pkg::SEG_LEAD_MARK;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    seg_d  = seg_q;
    if (done) begin
      busy_d = 1'b0;
    end else if (emit) begin
      seg_d = seg_next;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      seg_d  = cmd_i.start_seg;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    duty_d      = duty_q;
    us_d        = us_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = emit;
    end
    if (emit) begin
      last_d = (seg_q == cmd_q.end_seg);
      unique case (seg_q)
        irpd_pkg::SEG_LEAD_MARK: begin
          duty_d = cfg_i.carrier_duty;
          us_d   = cfg_i.leader_mark_us;
        end
        irpd_pkg::SEG_LEAD_SPACE: begin
          duty_d = '0;
          us_d   = cfg_i.leader_space_us;
        end
        irpd_pkg::SEG_BIT_MARK: begin
          duty_d = cfg_i.carrier_duty;
          us_d   = cfg_i.bit_mark_us;
        end
        irpd_pkg::SEG_BIT_SPACE: begin
          duty_d = '0;
          us_d   = cmd_q.bit_value ? cfg_i.one_space_us : cfg_i.zero_space_us;
        end
        irpd_pkg::SEG_TRAIL_MARK: begin
          duty_d = cfg_i.carrier_duty;
          us_d   = cfg_i.trailer_mark_us;
        end
        default: begin
          duty_d = '0;
          us_d   = cfg_i.gap_us;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      seg_q       <= irpd_pkg::SEG_LEAD_MARK;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    duty_q <= duty_d;
    us_q   <= us_d;
    last_q <= last_d;
  end

  assign seg_o.valid        = out_valid_q;
  assign seg_o.segment_duty = duty_q;
  assign seg_o.segment_us   = us_q;
  assign seg_o.last_segment = last_q;

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the infrared pulse-distance frame encoder unit.
// Depends on irpd_pkg, irpd_if and the RTL top; predicts segments per frame bit.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxReports   = 10;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TimeoutNs    = 10_000_000;

  typedef struct packed {
    logic bit_value;
    logic first_bit;
    logic last_bit;
  } frame_bit_t;

  typedef struct packed {
    logic [irpd_pkg::DutyW-1:0] duty;
    logic [irpd_pkg::TimeW-1:0] len_us;
    logic                       last_seg;
  } segment_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [irpd_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [irpd_pkg::CfgDataW-1:0] cfg_data_i;

  irpd_bit_if bit_if ();
  irpd_seg_if seg_if ();

  ir_pulse_distance_frame_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .bit_i      (bit_if),
    .seg_o      (seg_if)
  );

  irpd_pkg::cfg_t timing_cfg;
  frame_bit_t     bit_pend_q[$];
  segment_t       seg_exp_q[$];
  frame_bit_t     next_bit;
  segment_t       seg_got;
  segment_t       seg_want;
  int unsigned    fail_cnt;
  int unsigned    send_gap;
  int unsigned    stall_left;
  int unsigned    hold_left;
  int unsigned    hold_seq;
  int unsigned    hold_seen;
  bit             steady;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [irpd_pkg::TimeW-1:0] pick_time();
    int unsigned r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return irpd_pkg::TimeW'($urandom_range(65535));
  endfunction

  function automatic bit count_fail();
    count_fail = (fail_cnt < MaxReports);
    fail_cnt++;
  endfunction

  // Segments for one frame bit under the current timing registers.
  function automatic void add_frame_segments(logic bit_value, logic first_bit, logic last_bit);
    segment_t segs[$];
    if (first_bit) begin
      segs.push_back('{timing_cfg.carrier_duty, timing_cfg.leader_mark_us, 1'b0});
      segs.push_back('{'0, timing_cfg.leader_space_us, 1'b0});
    end
    segs.push_back('{timing_cfg.carrier_duty, timing_cfg.bit_mark_us, 1'b0});
    segs.push_back('{'0, bit_value ? timing_cfg.one_space_us : timing_cfg.zero_space_us,
                     1'b0});
    if (last_bit) begin
      segs.push_back('{timing_cfg.carrier_duty, timing_cfg.trailer_mark_us, 1'b0});
      segs.push_back('{'0, timing_cfg.gap_us, 1'b0});
    end
    segs[segs.size()-1].last_seg = 1'b1;
    foreach (segs[i]) seg_exp_q.push_back(segs[i]);
  endfunction

  // Sender: offers queued bits with random gaps, predicts on each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_if.valid     <= 1'b0;
      bit_if.bit_value <= 1'b0;
      bit_if.first_bit <= 1'b0;
      bit_if.last_bit  <= 1'b0;
      send_gap         <= 0;
    end else begin
      if (bit_if.valid && bit_if.ready) begin
        add_frame_segments(bit_if.bit_value, bit_if.first_bit, bit_if.last_bit);
      end
      if (!bit_if.valid || bit_if.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          bit_if.valid <= 1'b0;
        end else if (bit_pend_q.size() != 0) begin
          next_bit = bit_pend_q.pop_front();
          bit_if.valid     <= 1'b1;
          bit_if.bit_value <= next_bit.bit_value;
          bit_if.first_bit <= next_bit.first_bit;
          bit_if.last_bit  <= next_bit.last_bit;
          send_gap         <= steady ? 0 : pick_gap();
        end else begin
          bit_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_if.ready <= 1'b0;
      stall_left   <= 0;
      hold_left    <= 0;
      hold_seen    <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen    <= hold_seq;
      hold_left    <= LongHold;
      seg_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      seg_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      seg_if.ready <= 1'b0;
    end else if (steady) begin
      seg_if.ready <= 1'b1;
    end else begin
      stall_left   <= pick_gap();
      seg_if.ready <= ($urandom_range(3) != 0);
    end
  end

  // Segment checker against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && seg_if.valid && seg_if.ready) begin
      seg_got = '{seg_if.segment_duty, seg_if.segment_us, seg_if.last_segment};
      if (seg_exp_q.size() == 0) begin
        if (count_fail()) begin
          $display("%0t unexpected segment duty=%0d us=%0d last=%0b", $realtime,
                   seg_got.duty, seg_got.len_us, seg_got.last_seg);
        end
      end else begin
        seg_want = seg_exp_q.pop_front();
        if (seg_got.duty !== seg_want.duty || seg_got.len_us !== seg_want.len_us ||
            seg_got.last_seg !== seg_want.last_seg) begin
          if (count_fail()) begin
            $display("%0t mismatch: want duty=%0d us=%0d last=%0b, got duty=%0d us=%0d last=%0b",
                     $realtime, seg_want.duty, seg_want.len_us, seg_want.last_seg,
                     seg_got.duty, seg_got.len_us, seg_got.last_seg);
          end
        end
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (bit_pend_q.size() != 0 || bit_if.valid || seg_exp_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [irpd_pkg::CfgIdxW-1:0] idx,
                           logic [irpd_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      irpd_pkg::REG_LEADER_MARK:  timing_cfg.leader_mark_us  = data;
      irpd_pkg::REG_LEADER_SPACE: timing_cfg.leader_space_us = data;
      irpd_pkg::REG_BIT_MARK:     timing_cfg.bit_mark_us     = data;
      irpd_pkg::REG_ZERO_SPACE:   timing_cfg.zero_space_us   = data;
      irpd_pkg::REG_ONE_SPACE:    timing_cfg.one_space_us    = data;
      irpd_pkg::REG_TRAILER_MARK: timing_cfg.trailer_mark_us = data;
      irpd_pkg::REG_GAP:          timing_cfg.gap_us          = data;
      irpd_pkg::REG_CARRIER_DUTY: timing_cfg.carrier_duty    = data[irpd_pkg::DutyW-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The duty register gets junk in its upper byte, which must be dropped.
  task automatic program_timing(irpd_pkg::cfg_t c);
    write_reg(irpd_pkg::REG_LEADER_MARK, c.leader_mark_us);
    write_reg(irpd_pkg::REG_LEADER_SPACE, c.leader_space_us);
    write_reg(irpd_pkg::REG_BIT_MARK, c.bit_mark_us);
    write_reg(irpd_pkg::REG_ZERO_SPACE, c.zero_space_us);
    write_reg(irpd_pkg::REG_ONE_SPACE, c.one_space_us);
    write_reg(irpd_pkg::REG_TRAILER_MARK, c.trailer_mark_us);
    write_reg(irpd_pkg::REG_GAP, c.gap_us);
    write_reg(irpd_pkg::REG_CARRIER_DUTY, {8'($urandom_range(255)), c.carrier_duty});
    end_writes();
  endtask

  function automatic irpd_pkg::cfg_t random_timing();
    irpd_pkg::cfg_t c;
    c.leader_mark_us  = pick_time();
    c.leader_space_us = pick_time();
    c.bit_mark_us     = pick_time();
    c.zero_space_us   = pick_time();
    c.one_space_us    = pick_time();
    c.trailer_mark_us = pick_time();
    c.gap_us          = pick_time();
    c.carrier_duty    = irpd_pkg::DutyW'(pick_time());
    return c;
  endfunction

  // Mostly whole frames with random data, the rest loose bits with random flags.
  task automatic queue_frames(int unsigned n);
    int unsigned cnt;
    int unsigned len;
    int unsigned r;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        r   = $urandom_range(99);
        len = (r < 70) ? $urandom_range(6, 1) : (r < 90) ? 32 : $urandom_range(20, 7);
        if (len > n - cnt) len = n - cnt;
        for (int unsigned i = 0; i < len; i++) begin
          bit_pend_q.push_back('{1'($urandom_range(1)), i == 0, i == len - 1});
        end
        cnt += len;
      end else begin
        bit_pend_q.push_back(frame_bit_t'($urandom_range(7)));
        cnt++;
      end
    end
  endtask

  initial begin
    irpd_pkg::cfg_t c;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    fail_cnt   = 0;
    hold_seq   = 0;
    steady     = 1'b0;
    timing_cfg = '{irpd_pkg::LeaderMarkReset, irpd_pkg::LeaderSpaceReset,
                   irpd_pkg::BitMarkReset, irpd_pkg::ZeroSpaceReset,
                   irpd_pkg::OneSpaceReset, irpd_pkg::TrailerMarkReset,
                   irpd_pkg::GapReset, irpd_pkg::CarrierDutyReset};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset timings, every flag and data combination.
    for (int i = 0; i < 8; i++) bit_pend_q.push_back(frame_bit_t'(i));
    wait_drained();

    // All timings and the duty at their maximum.
    c = '{'1, '1, '1, '1, '1, '1, '1, '1};
    program_timing(c);
    bit_pend_q.push_back('{1'b1, 1'b1, 1'b1});
    bit_pend_q.push_back('{1'b0, 1'b1, 1'b0});
    bit_pend_q.push_back('{1'b1, 1'b0, 1'b0});
    bit_pend_q.push_back('{1'b0, 1'b0, 1'b1});
    wait_drained();

    // Zero-length segments and a zero duty.
    program_timing('0);
    bit_pend_q.push_back('{1'b0, 1'b1, 1'b1});
    bit_pend_q.push_back('{1'b1, 1'b1, 1'b0});
    bit_pend_q.push_back('{1'b0, 1'b0, 1'b0});
    bit_pend_q.push_back('{1'b1, 1'b0, 1'b1});
    wait_drained();

    // Writes to unused indexes must leave every timing untouched.
    program_timing(random_timing());
    for (int i = irpd_pkg::REG_CARRIER_DUTY + 1; i < (1 << irpd_pkg::CfgIdxW); i++) begin
      write_reg(irpd_pkg::CfgIdxW'(i), irpd_pkg::CfgDataW'($urandom));
    end
    end_writes();
    bit_pend_q.push_back('{1'b1, 1'b1, 1'b1});
    bit_pend_q.push_back('{1'b0, 1'b1, 1'b1});
    wait_drained();

    // Random timings with random gaps on both sides.
    program_timing(random_timing());
    queue_frames(80);
    wait_drained();

    // Receiver holds off while the sender keeps offering bits back to back.
    program_timing(random_timing());
    steady = 1'b1;
    @(posedge clk_i);
    hold_seq <= hold_seq + 1;
    queue_frames(80);
    wait_drained();
    steady = 1'b0;

    // Sender stops halfway until every segment has left.
    program_timing(random_timing());
    queue_frames(40);
    wait_drained();
    queue_frames(40);
    wait_drained();

    // Full rate on both sides.
    program_timing(random_timing());
    steady = 1'b1;
    queue_frames(80);
    wait_drained();
    steady = 1'b0;

    program_timing(random_timing());
    queue_frames(90);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/irpd_pkg.sv
rtl/irpd_if.sv
rtl/irpd_front.sv
rtl/irpd_queue.sv
rtl/irpd_back.sv
rtl/ir_pulse_distance_frame_encoder_unit.sv
test/tb.sv
